// ===== sv/sss_pkg.sv =====
// Shared types and constants for the sample statistics store.
package sss_pkg;

    localparam int unsigned StoreDepth = 256;
    localparam int unsigned SampleW    = 16;
    localparam int unsigned CountW     = 9;
    localparam int unsigned SumW       = 25;
    localparam int unsigned SqW        = 39;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Status codes.
    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    // Control sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MATH,
        S_MATH_WAIT,
        S_OUT
    } t_state;

    // Arithmetic unit states.
    typedef enum logic [2:0] {
        M_IDLE, M_MUL, M_MDIV, M_VDIV, M_SQRT, M_DONE
    } t_mstate;

    // Request to the arithmetic unit.
    typedef struct packed {
        logic                       start;
        logic [CountW-1:0]          n;
        logic signed [SumW-1:0]     sum;
        logic [SqW-1:0]             sumsq;
    } t_math_req;

    // Reply from the arithmetic unit.
    typedef struct packed {
        logic                       done;
        logic signed [SampleW-1:0]  mean;
        logic [SampleW-1:0]         sdev;
    } t_math_rsp;

endpackage

// ===== sv/sss_math.sv =====
// Iterative mean, variance division and square root unit.
module sss_math (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sss_pkg::t_math_req i_req,
    output sss_pkg::t_math_rsp o_rsp
);
    import sss_pkg::*;

    localparam int unsigned NumW = 64;
    localparam int unsigned DenW = 2 * CountW;

    t_mstate r_st, n_st;
    logic [6:0]            r_cnt, n_cnt;
    logic [NumW-1:0]       r_num, n_num;
    logic [NumW-1:0]       r_rem, n_rem;
    logic [NumW-1:0]       r_quo, n_quo;
    logic [DenW-1:0]       r_den, n_den;
    logic [CountW-1:0]     r_n;
    logic [SumW-1:0]       r_asum;
    logic                  r_neg;
    logic [SqW-1:0]        r_sumsq;
    logic [32:0]           r_root, n_root;
    logic [SampleW-1:0]    r_mean, n_mean;
    logic [SampleW-1:0]    r_sdev, n_sdev;

    logic [NumW:0]         w_trial;
    logic [NumW-1:0]       w_rsh;
    logic [NumW-1:0]       w_sq_trial;

    // Registered operands.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_n     <= i_req.n;
            r_neg   <= i_req.sum[SumW-1];
            r_asum  <= i_req.sum[SumW-1] ? SumW'(-i_req.sum) : SumW'(i_req.sum);
            r_sumsq <= i_req.sumsq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= M_IDLE;
        end else begin
            r_st <= n_st;
        end
        r_cnt  <= n_cnt;
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_den  <= n_den;
        r_root <= n_root;
        r_mean <= n_mean;
        r_sdev <= n_sdev;
    end

    // Restoring step shared by both divisions, and the two-bit shifted remainder for the root.
    assign w_rsh      = {r_rem[NumW-2:0], r_num[NumW-1]};
    assign w_trial    = {1'b0, w_rsh} - {{(NumW+1-DenW){1'b0}}, r_den};
    assign w_sq_trial = {r_rem[NumW-3:0], r_num[NumW-1:NumW-2]};

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            M_IDLE:  if (i_req.start) n_st = M_MUL;
            M_MUL:   n_st = M_MDIV;
            M_MDIV:  if (r_cnt == 7'd0) n_st = (r_n > CountW'(1)) ? M_VDIV : M_DONE;
            M_VDIV:  if (r_cnt == 7'd0) n_st = M_SQRT;
            M_SQRT:  if (r_cnt == 7'd0) n_st = M_DONE;
            M_DONE:  n_st = M_IDLE;
            default: n_st = M_IDLE;
        endcase
    end

    // Datapath.
    always_comb begin
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_root = r_root;
        n_mean = r_mean;
        n_sdev = r_sdev;
        unique case (r_st)
            M_IDLE: ;
            M_MUL: begin
                // Mean division set up: dividend is |sum| at the top.
                n_num  = {r_asum, {(NumW-SumW){1'b0}}};
                n_rem  = '0;
                n_quo  = '0;
                n_den  = DenW'(r_n);
                n_cnt  = 7'(SumW - 1);
                n_sdev = '0;
            end
            M_MDIV: begin
                if (!w_trial[NumW]) begin
                    n_rem = w_trial[NumW-1:0];
                    n_quo = {r_quo[NumW-2:0], 1'b1};
                end else begin
                    n_rem = w_rsh;
                    n_quo = {r_quo[NumW-2:0], 1'b0};
                end
                n_num = {r_num[NumW-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_mean = r_neg ? SampleW'(-n_quo[SumW-1:0]) : n_quo[SampleW-1:0];
                    n_num  = NumW'(r_n) * NumW'(r_sumsq) - NumW'(r_asum) * NumW'(r_asum);
                    n_rem  = '0;
                    n_quo  = '0;
                    n_den  = DenW'(r_n) * DenW'(r_n - CountW'(1));
                    n_cnt  = 7'(NumW - 1);
                end
            end
            M_VDIV: begin
                if (!w_trial[NumW]) begin
                    n_rem = w_trial[NumW-1:0];
                    n_quo = {r_quo[NumW-2:0], 1'b1};
                end else begin
                    n_rem = w_rsh;
                    n_quo = {r_quo[NumW-2:0], 1'b0};
                end
                n_num = {r_num[NumW-2:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_num  = n_quo;
                    n_rem  = '0;
                    n_root = '0;
                    n_cnt  = 7'(NumW/2 - 1);
                end
            end
            M_SQRT: begin
                // One root bit per cycle, digit-by-digit.
                if ({w_sq_trial} >= {r_root[30:0], 2'b01} + NumW'(0)) begin
                    n_rem  = w_sq_trial - NumW'({r_root[30:0], 2'b01});
                    n_root = {r_root[31:0], 1'b1};
                end else begin
                    n_rem  = w_sq_trial;
                    n_root = {r_root[31:0], 1'b0};
                end
                n_num = {r_num[NumW-3:0], 2'b00};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd0) begin
                    n_sdev = (n_root[32:16] != '0) ? '1 : n_root[SampleW-1:0];
                end
            end
            M_DONE: ;
            default: ;
        endcase
    end

    assign o_rsp.done = (r_st == M_DONE);
    assign o_rsp.mean = r_mean;
    assign o_rsp.sdev = r_sdev;
endmodule

// ===== sv/sss_ctrl.sv =====
// Sequencer and sample memory for the statistics store.
module sss_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  sss_pkg::t_cmd                  i_cmd,
    input  logic signed [sss_pkg::SampleW-1:0] i_value,
    input  logic                           i_out_taken,
    output logic                           o_busy,
    output logic                           o_res_valid,
    output sss_pkg::t_status               o_status,
    output logic [sss_pkg::CountW-1:0]     o_count,
    output logic signed [sss_pkg::SampleW-1:0] o_mean,
    output logic [sss_pkg::SampleW-1:0]    o_sdev,
    output logic signed [sss_pkg::SampleW-1:0] o_least,
    output logic signed [sss_pkg::SampleW-1:0] o_greatest
);
    import sss_pkg::*;

    localparam int unsigned AW = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
    localparam int unsigned NW = $clog2(StoreDepth + 1);

    logic signed [SampleW-1:0] r_mem [StoreDepth];
    logic signed [SampleW-1:0] r_rd;

    t_state r_st, n_st;
    logic [NW-1:0]  r_n, n_n;
    logic [NW-1:0]  r_idx, n_idx;
    logic signed [SumW-1:0] r_sum, n_sum;
    logic [SqW-1:0] r_sq, n_sq;
    logic signed [SampleW-1:0] r_val;
    t_status r_status, n_status;
    logic signed [SampleW-1:0] r_lo, n_lo, r_hi, n_hi;

    logic          w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic signed [SampleW-1:0] w_wd;
    logic signed [SampleW-1:0] w_sqin;
    logic [SqW-1:0] w_vsq;
    logic          w_full;

    t_math_req w_req;
    t_math_rsp w_rsp;

    // Square of the incoming sample on append, of the held value on delete.
    assign w_sqin = (r_st == S_IDLE) ? i_value : r_val;
    assign w_vsq  = SqW'($unsigned(32'(w_sqin * w_sqin)));
    assign w_full = (r_n == NW'(StoreDepth));

    // Sample memory, one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= S_IDLE;
            r_n   <= '0;
            r_sum <= '0;
            r_sq  <= '0;
        end else begin
            r_st  <= n_st;
            r_n   <= n_n;
            r_sum <= n_sum;
            r_sq  <= n_sq;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        if (i_go) begin
            r_val <= i_value;
        end
    end

    // Next state.
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE: if (i_go) begin
                n_st = (i_cmd == CMD_DELETE) ? S_SRCH_RD : S_SCAN_RD;
            end
            S_SRCH_RD:  n_st = (r_idx == '0) ? S_SCAN_RD : S_SRCH_CHK;
            S_SRCH_CHK: if (r_rd == r_val) n_st = S_SHIFT_RD;
                        else n_st = S_SRCH_RD;
            S_SHIFT_RD: n_st = (r_idx + NW'(1) >= r_n) ? S_SCAN_RD : S_SHIFT_WR;
            S_SHIFT_WR: n_st = S_SHIFT_RD;
            S_SCAN_RD:  n_st = (r_idx >= r_n) ? S_MATH : S_SCAN_CHK;
            S_SCAN_CHK: n_st = S_SCAN_RD;
            S_MATH:     n_st = (r_n == '0) ? S_OUT : S_MATH_WAIT;
            S_MATH_WAIT: if (w_rsp.done) n_st = S_OUT;
            S_OUT:      if (i_out_taken) n_st = S_IDLE;
            default:    n_st = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_n = r_n; n_sum = r_sum; n_sq = r_sq; n_idx = r_idx;
        n_status = r_status; n_lo = r_lo; n_hi = r_hi;
        w_we = 1'b0; w_wa = r_idx[AW-1:0]; w_wd = r_val; w_ra = r_idx[AW-1:0];
        unique case (r_st)
            S_IDLE: begin
                n_status = ST_DONE;
                n_idx    = r_n;
                n_lo     = '0;
                n_hi     = '0;
                if (i_go) begin
                    unique case (i_cmd)
                        CMD_CLEAR: begin
                            n_n = '0; n_sum = '0; n_sq = '0;
                        end
                        CMD_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                // Append is written before the rescan starts.
                                w_we  = 1'b1;
                                w_wa  = r_n[AW-1:0];
                                w_wd  = i_value;
                                n_n   = r_n + NW'(1);
                                n_sum = r_sum + SumW'(i_value);
                                n_sq  = r_sq + w_vsq;
                            end
                        end
                        CMD_DELETE: ;
                        CMD_NONE: ;
                        default: ;
                    endcase
                    if (i_cmd != CMD_DELETE) n_idx = '0;
                end
            end
            S_SRCH_RD: begin
                // Walk down from the newest entry.
                if (r_idx == '0) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_idx = r_idx - NW'(1);
                    w_ra  = n_idx[AW-1:0];
                end
            end
            S_SRCH_CHK: begin
                if (r_rd == r_val) begin
                    n_sum = r_sum - SumW'(r_val);
                    n_sq  = r_sq - w_vsq;
                    w_ra  = AW'(r_idx + NW'(1));
                end
            end
            S_SHIFT_RD: begin
                // Fetch the entry above the gap.
                w_ra = AW'(r_idx + NW'(1));
                if (r_idx + NW'(1) >= r_n) begin
                    n_n   = r_n - NW'(1);
                    n_idx = '0;
                end
            end
            S_SHIFT_WR: begin
                // Move the next entry down by one.
                w_we  = 1'b1;
                w_wd  = r_rd;
                n_idx = r_idx + NW'(1);
                w_ra  = AW'(r_idx + NW'(2));
            end
            S_SCAN_CHK: begin
                if (r_idx == '0 || r_rd < r_lo) n_lo = r_rd;
                if (r_idx == '0 || r_rd > r_hi) n_hi = r_rd;
                n_idx = r_idx + NW'(1);
                w_ra  = AW'(r_idx + NW'(1));
            end
            default: ;
        endcase
    end

    assign w_req.start = (r_st == S_MATH) && (r_n != '0);
    assign w_req.n     = CountW'(r_n);
    assign w_req.sum   = r_sum;
    assign w_req.sumsq = r_sq;

    sss_math u_math (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    logic r_empty;
    always_ff @(posedge i_clk) begin
        if (r_st == S_MATH) r_empty <= (r_n == '0);
    end

    assign o_busy      = (r_st != S_IDLE);
    assign o_res_valid = (r_st == S_OUT);
    assign o_status    = r_status;
    assign o_count     = CountW'(r_n);
    assign o_mean      = r_empty ? '0 : w_rsp.mean;
    assign o_sdev      = r_empty ? '0 : w_rsp.sdev;
    assign o_least     = r_empty ? '0 : r_lo;
    assign o_greatest  = r_empty ? '0 : r_hi;
endmodule

// ===== sv/sample_statistics_store.sv =====
// Top level of the sample statistics store.
// Channel  | Direction | Payload
// s_axis   | in        | tdata: cmd[1:0], value[17:2]
// m_axis   | out       | tdata: status, valid_res, count, mean, sdev, least, greatest
// Each transaction rescans the held samples for the minimum and maximum; a delete first
// searches for the value and, on a match, shifts the entries above it down. A non-empty
// store then runs the mean division, variance division and square root (only the mean
// division with one sample). The memory has a single read port. Reset is synchronous and
// active low and clears the count and sums. One transaction is in work at a time; the
// result is held until the master side takes it.
module sample_statistics_store (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // cmd[1:0], value[17:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata    // status, valid_res, count, mean, sdev, least, greatest
);
    import sss_pkg::*;

    logic w_go;
    t_status w_status;
    logic [CountW-1:0] w_count;
    logic signed [SampleW-1:0] w_mean, w_least, w_greatest;
    logic [SampleW-1:0] w_sdev;
    logic w_busy;

    assign s_axis_tready = !w_busy;
    assign w_go = s_axis_tvalid && s_axis_tready;

    sss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (w_go),
        .i_cmd      (t_cmd'(s_axis_tdata[1:0])),
        .i_value    (s_axis_tdata[17:2]),
        .i_out_taken(m_axis_tready),
        .o_busy     (w_busy),
        .o_res_valid(m_axis_tvalid),
        .o_status   (w_status),
        .o_count    (w_count),
        .o_mean     (w_mean),
        .o_sdev     (w_sdev),
        .o_least    (w_least),
        .o_greatest (w_greatest)
    );

    assign m_axis_tdata = {4'b0, w_greatest, w_least, w_sdev, w_mean, w_count,
                           (w_count != '0), w_status};

`ifndef SYNTH
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11:3] == 9'd0 |-> m_axis_tdata[75:2] == '0)
        else $error("empty store reports non-zero statistics");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result is pending");
`endif
endmodule

// ===== dv/sample_statistics_store_tb.sv =====
// Self-checking testbench for the sample statistics store, with a directed table and random traffic.
module sample_statistics_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sss_pkg::*;

    localparam int unsigned Depth = StoreDepth;

    // One result as carried on the master side, status in the lowest bits.
    typedef struct packed {
        logic signed [15:0] greatest;
        logic signed [15:0] least;
        logic [15:0]        sdev;
        logic signed [15:0] mean;
        logic [8:0]         count;
        logic               valid_res;
        logic [1:0]         status;
    } t_stats;

    // One row of the directed table; check_fixed marks a hand-typed expectation.
    typedef struct {
        t_cmd        cmd;
        logic [15:0] value;
        bit          check_fixed;
        t_stats      fixed;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // cmd[1:0], value[17:2], zero fill
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;   // status, valid_res, count, mean, sdev, least, greatest, zero fill

    sample_statistics_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Predictor state.
    logic signed [15:0] held_samples [Depth];
    int unsigned        held_n;
    longint             sum_acc;
    longint unsigned    sq_acc;

    t_stats pending_stats [$];
    int     errors;
    int     results_seen;
    int     appends_dropped;
    int     deletes_missed;
    int     send_idle_pct;
    int     recv_stall_pct;

    // Clock: period 10 ns.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Safety net on run time.
    initial begin
        #200ms;
        $display("sample_statistics_store_tb: FAIL");
        $finish;
    end

    function automatic longint unsigned isqrt(longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // Applies one command to the predictor and returns the statistics it reports.
    function automatic t_stats apply_command(t_cmd cmd, logic signed [15:0] v);
        t_stats          r;
        int              pos;
        longint          sq;
        longint unsigned asum;
        longint unsigned var_q;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        r = '0;
        r.status = ST_DONE;
        sq = longint'(v) * longint'(v);
        case (cmd)
            CMD_CLEAR: begin
                held_n = 0;
                sum_acc = 0;
                sq_acc = 0;
            end
            CMD_APPEND: begin
                if (held_n >= Depth) begin
                    r.status = ST_FULL;
                end else begin
                    held_samples[held_n] = v;
                    held_n++;
                    sum_acc += v;
                    sq_acc += sq;
                end
            end
            CMD_DELETE: begin
                pos = -1;
                for (int i = int'(held_n) - 1; i >= 0; i--) begin
                    if (held_samples[i] == v) begin
                        pos = i;
                        break;
                    end
                end
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    held_n--;
                    for (int i = pos; i < int'(held_n); i++) held_samples[i] = held_samples[i + 1];
                    sum_acc -= v;
                    sq_acc -= sq;
                end
            end
            default: ;
        endcase
        if (held_n != 0) begin
            lo = held_samples[0];
            hi = held_samples[0];
            for (int i = 1; i < int'(held_n); i++) begin
                if (held_samples[i] < lo) lo = held_samples[i];
                if (held_samples[i] > hi) hi = held_samples[i];
            end
            r.valid_res = 1'b1;
            r.count = held_n[8:0];
            r.mean = 16'(sum_acc / longint'(held_n));
            r.least = lo;
            r.greatest = hi;
            if (held_n > 1) begin
                asum = (sum_acc < 0) ? -sum_acc : sum_acc;
                var_q = (longint'(held_n) * sq_acc - asum * asum)
                        / (longint'(held_n) * longint'(held_n - 1));
                var_q = isqrt(var_q);
                r.sdev = (var_q > 64'hFFFF) ? 16'hFFFF : var_q[15:0];
            end
        end
        return r;
    endfunction

    // Sends one transaction and queues its expected statistics.
    task automatic send_item(t_cmd cmd, logic [15:0] v, bit check_fixed, t_stats fixed);
        t_stats predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, v, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predicted = apply_command(cmd, v);
        if (check_fixed && predicted !== fixed) begin
            $display("%0t: directed expectation disagrees, expected %h predicted %h",
                     $time, fixed, predicted);
            errors++;
        end
        if (predicted.status == ST_FULL) appends_dropped++;
        if (predicted.status == ST_NOTFOUND) deletes_missed++;
        pending_stats.push_back(predicted);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        // The block stays busy after the handshake, so the next item waits a falling edge.
        @(negedge i_clk);
    endtask

    // Result checker on the master side.
    always @(posedge i_clk) begin
        t_stats got;
        t_stats want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_stats'(m_axis_tdata[75:0]);
            results_seen++;
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = pending_stats.pop_front();
                if (got.status !== want.status)
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                if (got.valid_res !== want.valid_res)
                    $display("%0t: valid_res expected %0d actual %0d", $time,
                             want.valid_res, got.valid_res);
                if (got.count !== want.count)
                    $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
                if (got.mean !== want.mean)
                    $display("%0t: mean expected %0d actual %0d", $time, want.mean, got.mean);
                if (got.sdev !== want.sdev)
                    $display("%0t: sdev expected %0d actual %0d", $time, want.sdev, got.sdev);
                if (got.least !== want.least)
                    $display("%0t: least expected %0d actual %0d", $time, want.least, got.least);
                if (got.greatest !== want.greatest)
                    $display("%0t: greatest expected %0d actual %0d", $time,
                             want.greatest, got.greatest);
                if (got !== want) errors++;
            end
        end
    end

    // Receiver stalls.
    always @(negedge i_clk) begin
        m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end

    function automatic t_stats mk(int st, int vr, int cnt, int mn, int sd, int lo, int hi);
        t_stats r;
        r.status = st[1:0];
        r.valid_res = vr[0];
        r.count = cnt[8:0];
        r.mean = mn[15:0];
        r.sdev = sd[15:0];
        r.least = lo[15:0];
        r.greatest = hi[15:0];
        return r;
    endfunction

    task automatic wait_drained();
        while (pending_stats.size() != 0) @(negedge i_clk);
    endtask

    // Random sample, biased towards extremes and a small pool that makes deletes hit.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3, 4: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_row        rows [$];
        t_stats      none;
        logic [15:0] v;
        int          pick;
        none = '0;
        errors = 0;
        results_seen = 0;
        appends_dropped = 0;
        deletes_missed = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        held_n = 0;
        sum_acc = 0;
        sq_acc = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table: empty store, extremes, one sample, misses, ignored code, clear.
        rows.push_back('{CMD_DELETE, 16'd5,    1, mk(1, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_NONE,   16'd0,    1, mk(0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_APPEND, 16'h7FFF, 1, mk(0, 1, 1, 32767, 0, 32767, 32767)});
        rows.push_back('{CMD_APPEND, 16'h8000, 0, none});
        rows.push_back('{CMD_APPEND, 16'h8000, 0, none});
        rows.push_back('{CMD_APPEND, 16'hFFFF, 0, none});
        rows.push_back('{CMD_APPEND, 16'h0000, 0, none});
        rows.push_back('{CMD_APPEND, 16'h5555, 0, none});
        rows.push_back('{CMD_APPEND, 16'hAAAA, 0, none});
        rows.push_back('{CMD_DELETE, 16'h1234, 0, none});
        rows.push_back('{CMD_DELETE, 16'h8000, 0, none});
        rows.push_back('{CMD_NONE,   16'hFFFF, 0, none});
        rows.push_back('{CMD_DELETE, 16'h7FFF, 0, none});
        rows.push_back('{CMD_CLEAR,  16'hFFFF, 1, mk(0, 0, 0, 0, 0, 0, 0)});
        rows.push_back('{CMD_APPEND, 16'h8000, 1, mk(0, 1, 1, -32768, 0, -32768, -32768)});
        rows.push_back('{CMD_DELETE, 16'h8000, 1, mk(0, 0, 0, 0, 0, 0, 0)});
        foreach (rows[i]) send_item(rows[i].cmd, rows[i].value, rows[i].check_fixed, rows[i].fixed);

        // Fill to capacity with extremes of both signs, then overflow.
        for (int i = 0; i < Depth; i++) send_item(CMD_APPEND, (i % 2) ? 16'h8000 : 16'h7FFF, 0, none);
        send_item(CMD_APPEND, 16'd1, 0, none);
        send_item(CMD_DELETE, 16'h7FFF, 0, none);
        send_item(CMD_APPEND, 16'd3, 0, none);
        send_item(CMD_CLEAR, 16'd0, 0, none);

        // Random phases with differing handshake pressure.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 51 : (phase == 3) ? 16 : 0;
            recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 16 : 0;
            for (int n = 0; n < 180; n++) begin
                v = pick_value();
                pick = $urandom_range(99);
                if (pick < 2) send_item(CMD_CLEAR, v, 0, none);
                else if (pick < 4) send_item(CMD_NONE, v, 0, none);
                else if (pick < 30) send_item(CMD_DELETE,
                    (held_n != 0 && pick < 22) ? held_samples[$urandom_range(held_n - 1)] : v,
                    0, none);
                else send_item(CMD_APPEND, v, 0, none);
                if (n == 125) wait_drained();
            end
            wait_drained();
        end

        wait_drained();
        repeat (2000) @(negedge i_clk);
        $display("Covered %0d results, %0d appends to a full store, %0d deletes with no match.",
                 results_seen, appends_dropped, deletes_missed);
        if (errors == 0 && pending_stats.size() == 0) begin
            $display("sample_statistics_store_tb: PASS");
        end else begin
            $display("sample_statistics_store_tb: FAIL");
        end
        $finish;
    end
endmodule
